// ===== sv/tgcd_pkg.sv =====
// Shared widths, constants and sideband types of the gate crossing detector.
package tgcd_pkg;

    localparam int unsigned COORD_W = 32;   // coordinate and register width
    localparam int unsigned DIFF_W  = 33;   // difference of two coordinates
    localparam int unsigned OPA_W   = 34;   // narrow multiplier operand
    localparam int unsigned PROD_W  = 66;   // product of two differences
    localparam int unsigned DET_W   = 67;   // determinant width
    localparam int unsigned SPLIT   = 34;   // low slice of a wide operand
    localparam int unsigned WIDE_W  = 104;  // full product of narrow by determinant
    localparam int unsigned QUO_W   = 33;   // quotient bits before saturation
    localparam int unsigned REM_W   = 101;  // numerator and remainder width
    localparam int unsigned SPEED_W = 16;
    localparam int unsigned TADJ_W  = 32;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_GATE_AX = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_AY = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_BX = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GATE_BY = 8'd3;

    localparam logic [TADJ_W-1:0] TADJ_MAX = 32'h7FFF_FFFF;
    localparam logic [TADJ_W-1:0] TADJ_MIN = 32'h8000_0000;

    // travels with a request through the geometry stages
    typedef struct packed {
        logic               nofix;
        logic               xeq;
        logic               neg;
        logic [SPEED_W-1:0] speed;
    } t_geo_side;

    // travels with a request through the divider
    typedef struct packed {
        logic               ok;
        logic               ovf;
        logic               neg;
        logic [SPEED_W-1:0] speed;
    } t_div_side;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
    } t_gate;

endpackage

// ===== sv/tgcd_geom.sv =====
// Seven-stage geometry pipeline: determinants, span tests and division operands.
module tgcd_geom (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  tgcd_pkg::t_gate                       i_gate,
    input  logic signed [tgcd_pkg::COORD_W-1:0]   i_x1,
    input  logic signed [tgcd_pkg::COORD_W-1:0]   i_y1,
    input  logic        [31:0]                    i_t1,
    input  logic        [tgcd_pkg::SPEED_W-1:0]   i_v1,
    input  logic signed [tgcd_pkg::COORD_W-1:0]   i_x2,
    input  logic signed [tgcd_pkg::COORD_W-1:0]   i_y2,
    input  logic        [31:0]                    i_t2,
    input  logic        [tgcd_pkg::SPEED_W-1:0]   i_v2,
    output logic                                  o_valid,
    output tgcd_pkg::t_div_side                   o_side,
    output logic        [tgcd_pkg::REM_W-1:0]     o_num,
    output logic        [tgcd_pkg::DET_W-1:0]     o_den
);
    localparam int unsigned DW = tgcd_pkg::DIFF_W;
    localparam int unsigned AW = tgcd_pkg::OPA_W;
    localparam int unsigned EW = tgcd_pkg::DET_W;
    localparam int unsigned SP = tgcd_pkg::SPLIT;
    localparam int unsigned WW = tgcd_pkg::WIDE_W;
    localparam int unsigned HW = tgcd_pkg::DET_W - tgcd_pkg::SPLIT;
    localparam int unsigned NW = tgcd_pkg::REM_W;

    logic [7:1] r_v;
    tgcd_pkg::t_geo_side r_side [1:6];

    // stage 1: differences
    logic signed [DW-1:0] r1_dx, r1_dy, r1_gdx, r1_gdy, r1_ax2, r1_ay2, r1_ylo, r1_yhi;
    logic [DW-1:0]        r1_mag;
    logic signed [DW-1:0] n1_dt;
    logic signed [tgcd_pkg::COORD_W-1:0] n1_ymin, n1_ymax;
    logic [tgcd_pkg::SPEED_W:0] n1_vsum;

    always_comb begin
        n1_dt   = $signed({1'b0, i_t1}) - $signed({1'b0, i_t2});
        n1_ymin = (i_gate.ay < i_gate.by) ? i_gate.ay : i_gate.by;
        n1_ymax = (i_gate.ay < i_gate.by) ? i_gate.by : i_gate.ay;
        n1_vsum = {1'b0, i_v1} + {1'b0, i_v2};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dx  <= DW'(i_x1) - DW'(i_x2);
            r1_dy  <= DW'(i_y1) - DW'(i_y2);
            r1_gdx <= DW'(i_gate.ax) - DW'(i_gate.bx);
            r1_gdy <= DW'(i_gate.ay) - DW'(i_gate.by);
            r1_ax2 <= DW'(i_gate.ax) - DW'(i_x2);
            r1_ay2 <= DW'(i_gate.ay) - DW'(i_y2);
            r1_ylo <= DW'(i_y2) - DW'(n1_ymin);
            r1_yhi <= DW'(n1_ymax) - DW'(i_y2);
            r1_mag <= n1_dt[DW-1] ? DW'(-n1_dt) : DW'(n1_dt);
            r_side[1].nofix <= (i_x1 == '0) || (i_x2 == '0);
            r_side[1].xeq   <= (i_x1 == i_x2);
            r_side[1].neg   <= n1_dt[DW-1];
            r_side[1].speed <= n1_vsum[tgcd_pkg::SPEED_W:1];
        end
    end

    // stage 2: determinant products
    logic signed [tgcd_pkg::PROD_W-1:0] r2_pa, r2_pb, r2_pc, r2_pd;
    logic signed [DW-1:0] r2_ylo, r2_yhi, r2_dy;
    logic [DW-1:0]        r2_mag;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_pa  <= r1_dx * r1_gdy;
            r2_pb  <= r1_dy * r1_gdx;
            r2_pc  <= r1_ax2 * r1_gdy;
            r2_pd  <= r1_ay2 * r1_gdx;
            r2_ylo <= r1_ylo;
            r2_yhi <= r1_yhi;
            r2_dy  <= r1_dy;
            r2_mag <= r1_mag;
            r_side[2] <= r_side[1];
        end
    end

    // stage 3: D and S
    logic signed [EW-1:0] r3_d, r3_s;
    logic signed [DW-1:0] r3_ylo, r3_yhi, r3_dy;
    logic [DW-1:0]        r3_mag;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_d   <= EW'(r2_pa) - EW'(r2_pb);
            r3_s   <= EW'(r2_pc) - EW'(r2_pd);
            r3_ylo <= r2_ylo;
            r3_yhi <= r2_yhi;
            r3_dy  <= r2_dy;
            r3_mag <= r2_mag;
            r_side[3] <= r_side[2];
        end
    end

    // stage 4: make D positive
    logic signed [EW-1:0] r4_d, r4_s;
    logic                 r4_dz;
    logic signed [DW-1:0] r4_ylo, r4_yhi, r4_dy;
    logic [DW-1:0]        r4_mag;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_d   <= r3_d[EW-1] ? -r3_d : r3_d;
            r4_s   <= r3_d[EW-1] ? -r3_s : r3_s;
            r4_dz  <= (r3_d == '0);
            r4_ylo <= r3_ylo;
            r4_yhi <= r3_yhi;
            r4_dy  <= r3_dy;
            r4_mag <= r3_mag;
            r_side[4] <= r_side[3];
        end
    end

    // stage 5: partial products, wide operand split into high and low slices
    logic signed [AW+HW-1:0]   r5_ylo_h, r5_yhi_h, r5_sdy_h, r5_num_h;
    logic signed [AW+SP:0]     r5_ylo_l, r5_yhi_l, r5_sdy_l, r5_num_l;
    logic                      r5_xok, r5_dz;
    logic [EW-1:0]             r5_d;
    logic signed [EW-1:0]      n5_sabs;
    logic signed [EW:0]        n5_dms;
    logic signed [AW-1:0]      n5_ylo, n5_yhi, n5_dy, n5_mag;

    always_comb begin
        n5_sabs = r4_s[EW-1] ? -r4_s : r4_s;
        n5_dms  = (EW+1)'(r4_d) - (EW+1)'(r4_s);
        n5_ylo  = AW'(r4_ylo);
        n5_yhi  = AW'(r4_yhi);
        n5_dy   = AW'(r4_dy);
        n5_mag  = $signed({1'b0, r4_mag});
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_ylo_h <= n5_ylo * $signed(r4_d[EW-1:SP]);
            r5_ylo_l <= n5_ylo * $signed({1'b0, r4_d[SP-1:0]});
            r5_yhi_h <= n5_yhi * $signed(r4_d[EW-1:SP]);
            r5_yhi_l <= n5_yhi * $signed({1'b0, r4_d[SP-1:0]});
            r5_sdy_h <= n5_dy * $signed(r4_s[EW-1:SP]);
            r5_sdy_l <= n5_dy * $signed({1'b0, r4_s[SP-1:0]});
            r5_num_h <= n5_mag * $signed(n5_sabs[EW-1:SP]);
            r5_num_l <= n5_mag * $signed({1'b0, n5_sabs[SP-1:0]});
            r5_xok   <= r_side[4].xeq || (!r4_s[EW-1] && !n5_dms[EW]);
            r5_dz    <= r4_dz;
            r5_d     <= r4_d;
            r_side[5] <= r_side[4];
        end
    end

    // stage 6: assemble full products
    logic signed [WW-1:0] r6_ylod, r6_yhid, r6_sdy, r6_num;
    logic                 r6_xok, r6_dz;
    logic [EW-1:0]        r6_d;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_ylod <= (WW'(r5_ylo_h) <<< SP) + WW'(r5_ylo_l);
            r6_yhid <= (WW'(r5_yhi_h) <<< SP) + WW'(r5_yhi_l);
            r6_sdy  <= (WW'(r5_sdy_h) <<< SP) + WW'(r5_sdy_l);
            r6_num  <= (WW'(r5_num_h) <<< SP) + WW'(r5_num_l);
            r6_xok  <= r5_xok;
            r6_dz   <= r5_dz;
            r6_d    <= r5_d;
            r_side[6] <= r_side[5];
        end
    end

    // stage 7: y span test, overflow screen, division operands
    logic signed [WW-1:0] n7_lowt, n7_hight;
    logic [NW-1:0]        n7_num, n7_lim;

    always_comb begin
        n7_lowt  = r6_ylod + r6_sdy;
        n7_hight = r6_yhid - r6_sdy;
        n7_num   = r6_num[NW-1:0];
        n7_lim   = {(NW-EW)'(0), r6_d} << tgcd_pkg::QUO_W;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side.ok    <= !r_side[6].nofix && !r6_dz && r6_xok
                            && !n7_lowt[WW-1] && !n7_hight[WW-1];
            o_side.ovf   <= (n7_num >= n7_lim);
            o_side.neg   <= r_side[6].neg;
            o_side.speed <= r_side[6].speed;
            o_num        <= n7_num;
            o_den        <= r6_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[6:1], i_valid};
        end
    end

    assign o_valid = r_v[7];
endmodule

// ===== sv/tgcd_div.sv =====
// Pipelined restoring divider: one quotient bit per stage.
module tgcd_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  tgcd_pkg::t_div_side                i_side,
    input  logic [tgcd_pkg::REM_W-1:0]         i_num,
    input  logic [tgcd_pkg::DET_W-1:0]         i_den,
    output logic                               o_valid,
    output tgcd_pkg::t_div_side                o_side,
    output logic [tgcd_pkg::QUO_W-1:0]         o_quo,
    output logic                               o_rem_nz
);
    localparam int unsigned NQ = tgcd_pkg::QUO_W;
    localparam int unsigned NW = tgcd_pkg::REM_W;
    localparam int unsigned EW = tgcd_pkg::DET_W;

    logic [NQ:0]          r_v;
    tgcd_pkg::t_div_side  r_side [0:NQ];
    logic [NW-1:0]        r_rem  [0:NQ];
    logic [EW-1:0]        r_den  [0:NQ];
    logic [NQ-1:0]        r_quo  [0:NQ];

    assign r_v[0]    = i_valid;
    assign r_side[0] = i_side;
    assign r_rem[0]  = i_num;
    assign r_den[0]  = i_den;
    assign r_quo[0]  = '0;

    for (genvar k = 0; k < NQ; k++) begin : g_stage
        localparam int unsigned SH = NQ - 1 - k;
        logic [NW-1:0] n_cmp;
        logic          n_ge;
        assign n_cmp = {(NW-EW)'(0), r_den[k]} << SH;
        assign n_ge  = (r_rem[k] >= n_cmp);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= n_ge ? r_rem[k] - n_cmp : r_rem[k];
                r_quo[k+1]  <= r_quo[k] | (NQ'(n_ge) << SH);
                r_den[k+1]  <= r_den[k];
                r_side[k+1] <= r_side[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    assign o_valid  = r_v[NQ];
    assign o_side   = r_side[NQ];
    assign o_quo    = r_quo[NQ];
    assign o_rem_nz = (r_rem[NQ] != '0);
endmodule

// ===== sv/track_gate_crossing_detector_core.sv =====
// Top level of the gate crossing detector: gate registers, pipeline and result register.
//
// Input channel: i_valid / o_stall with one port per fix field; a request is
// taken at a rising edge with i_valid high and o_stall low. Output channel:
// o_valid / i_stall with o_crossed, o_crossing_speed, o_time_adjust.
// Gate endpoints are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// writes them only while the block is idle, which the block does not enforce; indexes above 3 are ignored.
// Throughput: one request per cycle while o_stall is low. The pipeline has 41
// register stages, the first loaded at the accepting edge: seven
// geometry stages, a 33-stage divider that resolves one quotient bit per
// stage, and the result register.
// Every request yields exactly one result; crossed is 0 (speed and time
// adjust 0) for a missing fix, parallel lines or a point outside the spans.
// Reset is synchronous: valid bits clear and gate registers go to 0.
// When i_stall is high while a result waits, the whole pipeline holds and
// o_stall rises in the same cycle; nothing is dropped or repeated.
module track_gate_crossing_detector_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [tgcd_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [tgcd_pkg::COORD_W-1:0]           i_cfg_data,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [tgcd_pkg::COORD_W-1:0]    i_first_x,
    input  logic signed [tgcd_pkg::COORD_W-1:0]    i_first_y,
    input  logic [31:0]                            i_first_time,
    input  logic [tgcd_pkg::SPEED_W-1:0]           i_first_speed,
    input  logic signed [tgcd_pkg::COORD_W-1:0]    i_second_x,
    input  logic signed [tgcd_pkg::COORD_W-1:0]    i_second_y,
    input  logic [31:0]                            i_second_time,
    input  logic [tgcd_pkg::SPEED_W-1:0]           i_second_speed,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_crossed,
    output logic [tgcd_pkg::SPEED_W-1:0]           o_crossing_speed,
    output logic signed [tgcd_pkg::TADJ_W-1:0]     o_time_adjust
);
    localparam int unsigned NQ = tgcd_pkg::QUO_W;

    tgcd_pkg::t_gate r_gate;
    logic en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tgcd_pkg::REG_GATE_AX: r_gate.ax <= i_cfg_data;
                tgcd_pkg::REG_GATE_AY: r_gate.ay <= i_cfg_data;
                tgcd_pkg::REG_GATE_BX: r_gate.bx <= i_cfg_data;
                tgcd_pkg::REG_GATE_BY: r_gate.by <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic                                geo_valid;
    tgcd_pkg::t_div_side                 geo_side;
    logic [tgcd_pkg::REM_W-1:0]          geo_num;
    logic [tgcd_pkg::DET_W-1:0]          geo_den;

    tgcd_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_gate  (r_gate),
        .i_x1    (i_first_x),
        .i_y1    (i_first_y),
        .i_t1    (i_first_time),
        .i_v1    (i_first_speed),
        .i_x2    (i_second_x),
        .i_y2    (i_second_y),
        .i_t2    (i_second_time),
        .i_v2    (i_second_speed),
        .o_valid (geo_valid),
        .o_side  (geo_side),
        .o_num   (geo_num),
        .o_den   (geo_den)
    );

    logic                 div_valid;
    tgcd_pkg::t_div_side  div_side;
    logic [NQ-1:0]        div_quo;
    logic                 div_rem_nz;

    tgcd_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (geo_valid),
        .i_side   (geo_side),
        .i_num    (geo_num),
        .i_den    (geo_den),
        .o_valid  (div_valid),
        .o_side   (div_side),
        .o_quo    (div_quo),
        .o_rem_nz (div_rem_nz)
    );

    // floor toward minus infinity: round the magnitude up when negative
    logic [NQ:0]                 n_qc;
    logic [tgcd_pkg::TADJ_W-1:0] n_adj;

    always_comb begin
        n_qc = {1'b0, div_quo} + (NQ+1)'(div_rem_nz);
        if (div_side.neg) begin
            if (div_side.ovf || n_qc > (NQ+1)'(tgcd_pkg::TADJ_MIN)) begin
                n_adj = tgcd_pkg::TADJ_MIN;
            end else begin
                n_adj = -n_qc[tgcd_pkg::TADJ_W-1:0];
            end
        end else begin
            if (div_side.ovf || div_quo[NQ-1] || div_quo[NQ-2]) begin
                n_adj = tgcd_pkg::TADJ_MAX;
            end else begin
                n_adj = div_quo[tgcd_pkg::TADJ_W-1:0];
            end
        end
    end

    logic r_out_valid;

    assign o_stall = r_out_valid && i_stall;
    assign en      = !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_crossed        <= div_side.ok;
            o_crossing_speed <= div_side.ok ? div_side.speed : '0;
            o_time_adjust    <= div_side.ok ? n_adj : '0;
        end
    end

    assign o_valid = r_out_valid;
endmodule

// ===== sv/tgcd_checker.sv =====
// Port-level checker for the gate crossing detector and its bind.
module tgcd_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               o_stall,
    input  logic                               o_valid,
    input  logic                               i_stall,
    input  logic                               o_crossed,
    input  logic [tgcd_pkg::SPEED_W-1:0]       o_crossing_speed,
    input  logic signed [tgcd_pkg::TADJ_W-1:0] o_time_adjust
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_crossed |-> o_crossing_speed == '0 && o_time_adjust == '0)
        else $error("nonzero payload without crossing");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_bp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without waiting result");
endmodule

bind track_gate_crossing_detector_core tgcd_checker u_tgcd_checker (.*);
